/* src/pdr_pkg.sv */
// pdr_pkg: shared constants and the cordic arctangent table for the
// planar dead-reckoning block; no dependencies
package pdr_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	localparam int TIME_W = 32;
	localparam int SPEED_W = 18;
	localparam int RATE_W = 32;
	localparam int POS_W = 48;
	localparam int ANG_W = 32;
	localparam int GAIN_W = 16;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_HEADING = 8'd1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;
	localparam logic signed [33:0] KINV_Q30 = 34'sh026DD3B6A;

	// binary-angle arctangent of 2^-i, 2^-32 turn
	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

/* src/pdr_if.sv */
// pdr_if: valid/ready channel interfaces for samples, results and
// register writes; depends on pdr_pkg for field widths
interface pdr_sample_if;
	logic valid;
	logic ready;
	logic [pdr_pkg::TIME_W-1:0] sample_time;
	logic signed [pdr_pkg::SPEED_W-1:0] speed;
	logic signed [pdr_pkg::RATE_W-1:0] yaw_rate;
	logic first_sample;

	modport source (output valid, sample_time, speed, yaw_rate, first_sample, input ready);
	modport sink (input valid, sample_time, speed, yaw_rate, first_sample, output ready);
endinterface

interface pdr_result_if;
	logic valid;
	logic ready;
	logic signed [pdr_pkg::POS_W-1:0] pos_x;
	logic signed [pdr_pkg::POS_W-1:0] pos_y;
	logic [pdr_pkg::ANG_W-1:0] heading_now;

	modport source (output valid, pos_x, pos_y, heading_now, input ready);
	modport sink (input valid, pos_x, pos_y, heading_now, output ready);
endinterface

interface pdr_cfg_if;
	logic valid;
	logic ready;
	logic [pdr_pkg::CFG_IDX_W-1:0] index;
	logic [pdr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/planar_dead_reckoning.sv */
// planar_dead_reckoning: 2-d dead-reckoning integrator built around one
// shared 35x17 multiplier and an iterative cordic under a small sequencer
// depends on pdr_pkg and the channel interfaces in pdr_if.sv
//
// usage:
//  - smp carries one timestamped sample (time, speed, yaw rate, first flag)
//  - res returns one result per sample: x/y displacement and heading
//  - cfg writes speed_gain (index 0) or initial_heading (index 1); other
//    indexes are dropped; cfg.ready is always high, write only while idle
// sequence:
//  - a first sample goes from acceptance straight to the final step, which
//    loads the output register and then returns the sequencer to idle
//  - any other sample runs the heading product, the speed-gain product,
//    one cordic iteration a cycle, a saturation step, then four split
//    products per axis; every product goes through the one multiplier
//  - smp.ready is high only while the sequencer is idle, so a new sample
//    is not accepted until the sequencer is through with the previous one
// reset clears the run state and loads speed_gain with 1.0
// the result sits in an output register; a stalled receiver holds it there
// while the next sample is accepted and worked on, and the sequencer waits
// at its last step only if that next result is ready before the old one left
module planar_dead_reckoning (
	input logic clk,
	input logic arst_n,
	pdr_sample_if.sink smp,
	pdr_result_if.source res,
	pdr_cfg_if.sink cfg
);
	import pdr_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_H_HI = 4'd1;
	localparam logic [3:0] S_H_LO = 4'd2;
	localparam logic [3:0] S_H_ADD = 4'd3;
	localparam logic [3:0] S_VG = 4'd4;
	localparam logic [3:0] S_CORD = 4'd5;
	localparam logic [3:0] S_CSAT = 4'd6;
	localparam logic [3:0] S_C_HI = 4'd7;
	localparam logic [3:0] S_C_LO = 4'd8;
	localparam logic [3:0] S_C_ADD = 4'd9;
	localparam logic [3:0] S_D_HI = 4'd10;
	localparam logic [3:0] S_D_LO = 4'd11;
	localparam logic [3:0] S_D_ADD = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	localparam logic signed [33:0] Q30_POS = 34'sh040000000;
	localparam logic signed [33:0] Q30_NEG = -34'sh040000000;
	localparam logic signed [49:0] POS_MAX50 = 50'sh00007FFFFFFFFFFF;
	localparam logic signed [49:0] POS_MIN50 = -50'sh000800000000000;
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
	localparam logic [ITER_W-1:0] ITER_ONE = ITER_W'(1);

	logic [3:0] state_q;
	logic [ITER_W-1:0] iter_q;
	logic sel_y_q;
	logic out_valid_q;

	logic [GAIN_W-1:0] gain_q;
	logic [ANG_W-1:0] init_heading_q;

	logic [TIME_W-1:0] prev_time_q;
	logic signed [SPEED_W-1:0] prev_speed_q;
	logic [ANG_W-1:0] heading_q;
	logic signed [POS_W-1:0] acc_x_q;
	logic signed [POS_W-1:0] acc_y_q;

	logic [TIME_W-1:0] dt_q;
	logic signed [RATE_W-1:0] rate_q;
	logic signed [SPEED_W-1:0] vspd_q;
	logic signed [33:0] vg_q;
	logic signed [34:0] v_q;
	logic signed [31:0] cos_q;
	logic signed [31:0] sin_q;
	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic signed [33:0] cz_q;
	logic flip_q;

	logic signed [51:0] prod_q;
	logic signed [67:0] big_q;

	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic [ANG_W-1:0] heading_out_q;

	logic signed [34:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [31:0] c_sel;
	logic signed [67:0] sum68;
	logic signed [48:0] inc49;
	logic signed [49:0] acc_sel50;
	logic signed [49:0] acc_sum50;
	logic signed [POS_W-1:0] acc_sat;
	logic signed [33:0] sh_x;
	logic signed [33:0] sh_y;
	logic signed [33:0] atan_z;
	logic signed [33:0] xf;
	logic signed [33:0] yf;
	logic [ANG_W-1:0] h_fold;
	logic h_flip;
	logic in_take;
	logic out_free;

	assign smp.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign res.valid = out_valid_q;
	assign res.pos_x = pos_x_q;
	assign res.pos_y = pos_y_q;
	assign res.heading_now = heading_out_q;

	assign in_take = smp.valid && smp.ready;
	assign out_free = !out_valid_q || res.ready;

	assign c_sel = sel_y_q ? sin_q : cos_q;

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			S_H_HI: begin
				mul_a = {{3{rate_q[31]}}, rate_q};
				mul_b = {1'b0, dt_q[31:16]};
			end
			S_H_LO: begin
				mul_a = {{3{rate_q[31]}}, rate_q};
				mul_b = {1'b0, dt_q[15:0]};
			end
			S_H_ADD: begin
				mul_a = {{17{vspd_q[17]}}, vspd_q};
				mul_b = {1'b0, gain_q};
			end
			S_C_HI: begin
				mul_a = {vg_q[33], vg_q};
				mul_b = {c_sel[31], c_sel[31:16]};
			end
			S_C_LO: begin
				mul_a = {vg_q[33], vg_q};
				mul_b = {1'b0, c_sel[15:0]};
			end
			S_D_HI: begin
				mul_a = v_q;
				mul_b = {1'b0, dt_q[31:16]};
			end
			S_D_LO: begin
				mul_a = v_q;
				mul_b = {1'b0, dt_q[15:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// high partial product already shifted up by 16 in big_q
	assign sum68 = big_q + {{16{prod_q[51]}}, prod_q};
	assign inc49 = sum68[66:18];
	assign acc_sel50 = sel_y_q ? {{2{acc_y_q[47]}}, acc_y_q} : {{2{acc_x_q[47]}}, acc_x_q};
	assign acc_sum50 = acc_sel50 + {inc49[48], inc49};

	always_comb begin
		if (acc_sum50 > POS_MAX50) begin
			acc_sat = POS_MAX50[47:0];
		end else if (acc_sum50 < POS_MIN50) begin
			acc_sat = POS_MIN50[47:0];
		end else begin
			acc_sat = acc_sum50[47:0];
		end
	end

	// shared cordic shifter and angle table
	assign sh_x = cy_q >>> iter_q;
	assign sh_y = cx_q >>> iter_q;
	assign atan_z = {2'b00, atan_entry(5'(iter_q))};

	// fold the heading into a quarter turn either side of zero
	assign h_flip = heading_q[31] ^ heading_q[30];
	assign h_fold = h_flip ? (heading_q + 32'h8000_0000) : heading_q;

	assign xf = flip_q ? -cx_q : cx_q;
	assign yf = flip_q ? -cy_q : cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			init_heading_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_SPEED_GAIN) begin
				gain_q <= cfg.data[GAIN_W-1:0];
			end else if (cfg.index == REG_INIT_HEADING) begin
				init_heading_q <= cfg.data[ANG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 52'(mul_a) * 52'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q <= '0;
			sel_y_q <= 1'b0;
			out_valid_q <= 1'b0;
			prev_time_q <= '0;
			prev_speed_q <= '0;
			heading_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						prev_time_q <= smp.sample_time;
						prev_speed_q <= smp.speed;
						sel_y_q <= 1'b0;
						if (smp.first_sample) begin
							acc_x_q <= '0;
							acc_y_q <= '0;
							heading_q <= init_heading_q;
							state_q <= S_DONE;
						end else begin
							state_q <= S_H_HI;
						end
					end
				end
				S_H_HI: state_q <= S_H_LO;
				S_H_LO: state_q <= S_H_ADD;
				S_H_ADD: begin
					heading_q <= heading_q + sum68[43:12];
					state_q <= S_VG;
				end
				S_VG: begin
					iter_q <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					iter_q <= iter_q + ITER_ONE;
					if (iter_q == ITER_LAST) begin
						state_q <= S_CSAT;
					end
				end
				S_CSAT: state_q <= S_C_HI;
				S_C_HI: state_q <= S_C_LO;
				S_C_LO: state_q <= S_C_ADD;
				S_C_ADD: state_q <= S_D_HI;
				S_D_HI: state_q <= S_D_LO;
				S_D_LO: state_q <= S_D_ADD;
				S_D_ADD: begin
					if (sel_y_q) begin
						acc_y_q <= acc_sat;
						state_q <= S_DONE;
					end else begin
						acc_x_q <= acc_sat;
						sel_y_q <= 1'b1;
						state_q <= S_C_HI;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				dt_q <= smp.sample_time - prev_time_q;
				rate_q <= smp.yaw_rate;
				vspd_q <= prev_speed_q;
			end
			S_H_LO, S_C_LO, S_D_LO: begin
				big_q <= {prod_q, 16'd0};
			end
			S_VG: begin
				vg_q <= prod_q[33:0];
				flip_q <= h_flip;
				cx_q <= KINV_Q30;
				cy_q <= '0;
				cz_q <= {{2{h_fold[31]}}, h_fold};
			end
			S_CORD: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - sh_x;
					cy_q <= cy_q + sh_y;
					cz_q <= cz_q - atan_z;
				end else begin
					cx_q <= cx_q + sh_x;
					cy_q <= cy_q - sh_y;
					cz_q <= cz_q + atan_z;
				end
			end
			S_CSAT: begin
				if (xf > Q30_POS) begin
					cos_q <= Q30_POS[31:0];
				end else if (xf < Q30_NEG) begin
					cos_q <= Q30_NEG[31:0];
				end else begin
					cos_q <= xf[31:0];
				end
				if (yf > Q30_POS) begin
					sin_q <= Q30_POS[31:0];
				end else if (yf < Q30_NEG) begin
					sin_q <= Q30_NEG[31:0];
				end else begin
					sin_q <= yf[31:0];
				end
			end
			S_C_ADD: begin
				v_q <= sum68[64:30];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			pos_x_q <= acc_x_q;
			pos_y_q <= acc_y_q;
			heading_out_q <= heading_q;
		end
	end

	// a first-sample transaction loads the configured heading
	a_first_heading: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && smp.first_sample) |=> (heading_q == $past(init_heading_q)))
		else $error("first sample did not load initial heading");

	// an accepted sample always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q != S_IDLE))
		else $error("sequencer stayed idle after accepting a sample");

	// cordic iterations advance by one each cycle
	a_cord_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CORD && iter_q != ITER_LAST) |=>
		(state_q == S_CORD && iter_q == $past(iter_q) + ITER_ONE))
		else $error("cordic iteration count skipped");

	// a new result only appears from the final step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the final step");

endmodule
